FILE: rtl/smaa_edge_detect_macros.svh
// ----------------------------------------------------------------------------
// smaa_edge_detect_macros.svh
// assertion macros used by the edge detection rtl
// ----------------------------------------------------------------------------
`ifndef SMAA_EDGE_DETECT_MACROS_SVH
`define SMAA_EDGE_DETECT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SMAA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define SMAA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SMAA_ASSERT_NOW(lbl, ante, cons, msg)
`define SMAA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/smaa_ed_pkg.sv
// ----------------------------------------------------------------------------
// smaa_ed_pkg
// shared types and constants of the edge detection block
// ----------------------------------------------------------------------------
`default_nettype none

package smaa_ed_pkg;

   // luma weights, q0.12
   localparam int LUMA_R = 871;
   localparam int LUMA_G = 2929;
   localparam int LUMA_B = 296;
   localparam int LUMA_RND = 2048;

   localparam int LIM_W = 45;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 16;
   localparam int FIFO_DEPTH = 4;

   // detect modes
   localparam logic [2:0] MODE_LUMA = 3'd0;
   localparam logic [2:0] MODE_COLOR = 3'd1;
   localparam logic [2:0] MODE_DEPTH = 3'd2;
   localparam logic [2:0] MODE_LUMA_PRED = 3'd3;
   localparam logic [2:0] MODE_COLOR_PRED = 3'd4;

   // request actions
   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DETECT_MODE = 4'd0,
      REG_FRAME_WIDTH = 4'd1,
      REG_EDGE_THRESHOLD = 4'd2,
      REG_ADAPT_FACTOR = 4'd3,
      REG_PRED_THRESHOLD = 4'd4,
      REG_PRED_STRENGTH = 4'd5,
      REG_PRED_SCALE = 4'd6,
      REG_DEPTH_THRESHOLD = 4'd7
   } reg_index_type;

   // decoded settings for the edge evaluator
   typedef struct packed {
      logic depth;
      logic colour;
      logic pred;
      logic [15:0] pred_thr;
      logic [15:0] depth_thr;
      logic [15:0] adapt;
      logic [LIM_W-1:0] lim_full;
      logic [LIM_W-1:0] lim_red;
   } smaa_cfg_type;

   typedef struct packed {
      logic [10:0] pixel_x;
      logic [11:0] pixel_y;
      logic edge_west;
      logic edge_north;
      logic last;
   } smaa_res_type;

endpackage

`default_nettype wire

FILE: rtl/smaa_ed_if.sv
// ----------------------------------------------------------------------------
// smaa_ed_if
// handshake channels of the edge detection block
// ----------------------------------------------------------------------------
`default_nettype none

interface smaa_req_if #(parameter int CHANNEL_BITS = 16);
   logic valid;
   logic ready;
   logic action;
   logic [CHANNEL_BITS-1:0] red;
   logic [CHANNEL_BITS-1:0] green;
   logic [CHANNEL_BITS-1:0] blue;
   logic [CHANNEL_BITS-1:0] aux_value;
   modport source (output valid, action, red, green, blue, aux_value, input ready);
   modport sink (input valid, action, red, green, blue, aux_value, output ready);
endinterface

interface smaa_rsp_if;
   logic valid;
   logic ready;
   logic [10:0] pixel_x;
   logic [11:0] pixel_y;
   logic edge_west;
   logic edge_north;
   logic last;
   modport source (output valid, pixel_x, pixel_y, edge_west, edge_north, last,
                   input ready);
   modport sink (input valid, pixel_x, pixel_y, edge_west, edge_north, last,
                 output ready);
endinterface

interface smaa_csr_if;
   logic valid;
   logic ready;
   logic [3:0] index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/smaa_ed_eval.sv
// ----------------------------------------------------------------------------
// smaa_ed_eval
// west and north edge decision for one window position
// ----------------------------------------------------------------------------
`default_nettype none

module smaa_ed_eval
   import smaa_ed_pkg::*;
#(
   parameter int CHANNEL_BITS = 16,
   localparam int PIX_W = 5 * CHANNEL_BITS
) (
   input  smaa_cfg_type     cfg,
   input  logic [PIX_W-1:0] pix_ll,
   input  logic [PIX_W-1:0] pix_l,
   input  logic [PIX_W-1:0] pix_h,
   input  logic [PIX_W-1:0] pix_r,
   input  logic [PIX_W-1:0] pix_t2,
   input  logic [PIX_W-1:0] pix_t1,
   input  logic [PIX_W-1:0] pix_bt,
   output logic             edge_west,
   output logic             edge_north
);

   localparam int CB = CHANNEL_BITS;
   localparam int CMP_W = (CB + 24 > LIM_W) ? CB + 24 : LIM_W;
   localparam int AD_W = CB + 16;
   localparam int AW = (CB > 16) ? CB : 16;

   function automatic logic [CB-1:0] absd(input logic [CB-1:0] a, input logic [CB-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // luma or largest channel difference
   function automatic logic [CB-1:0] dlt(input logic [PIX_W-1:0] a,
                                        input logic [PIX_W-1:0] b, input logic colour);
      logic [CB-1:0] dr;
      logic [CB-1:0] dg;
      logic [CB-1:0] db;
      logic [CB-1:0] m;
      dr = absd(a[0 +: CB], b[0 +: CB]);
      dg = absd(a[CB +: CB], b[CB +: CB]);
      db = absd(a[2*CB +: CB], b[2*CB +: CB]);
      m = (dr > dg) ? dr : dg;
      m = (m > db) ? m : db;
      return colour ? m : absd(a[4*CB +: CB], b[4*CB +: CB]);
   endfunction

   logic [CB-1:0] d_l, d_t, d_r, d_b, d_ll, d_tt, fin;
   logic [AW-1:0] aux_l, aux_t;
   logic [LIM_W-1:0] lim_w, lim_n;
   logic [CMP_W-1:0] sh_l, sh_t;
   logic [AD_W-1:0] fin_sh, prod_l, prod_t;
   logic thr_w, thr_n;

   always_comb begin
      d_l = dlt(pix_h, pix_l, cfg.colour);
      d_t = dlt(pix_h, pix_t1, cfg.colour);
      d_r = dlt(pix_h, pix_r, cfg.colour);
      d_b = dlt(pix_h, pix_bt, cfg.colour);
      d_ll = dlt(pix_l, pix_ll, cfg.colour);
      d_tt = dlt(pix_t1, pix_t2, cfg.colour);
      fin = (d_l > d_t) ? d_l : d_t;
      fin = (fin > d_r) ? fin : d_r;
      fin = (fin > d_b) ? fin : d_b;
      fin = (fin > d_ll) ? fin : d_ll;
      fin = (fin > d_tt) ? fin : d_tt;

      aux_l = AW'(absd(pix_h[3*CB +: CB], pix_l[3*CB +: CB]));
      aux_t = AW'(absd(pix_h[3*CB +: CB], pix_t1[3*CB +: CB]));

      // predication lowers the threshold where aux changes
      lim_w = (cfg.pred && (aux_l >= AW'(cfg.pred_thr))) ? cfg.lim_red : cfg.lim_full;
      lim_n = (cfg.pred && (aux_t >= AW'(cfg.pred_thr))) ? cfg.lim_red : cfg.lim_full;
      sh_l = CMP_W'({d_l, 24'd0});
      sh_t = CMP_W'({d_t, 24'd0});
      thr_w = sh_l >= CMP_W'(lim_w);
      thr_n = sh_t >= CMP_W'(lim_n);

      // local contrast adaptation
      fin_sh = AD_W'({fin, 12'd0});
      prod_l = AD_W'(cfg.adapt) * AD_W'(d_l);
      prod_t = AD_W'(cfg.adapt) * AD_W'(d_t);

      if (cfg.depth) begin
         edge_west = aux_l >= AW'(cfg.depth_thr);
         edge_north = aux_t >= AW'(cfg.depth_thr);
      end else begin
         edge_west = thr_w && !(fin_sh > prod_l);
         edge_north = thr_n && !(fin_sh > prod_t);
      end
   end

endmodule

`default_nettype wire

FILE: rtl/smaa_edge_detect.sv
// ----------------------------------------------------------------------------
// smaa_edge_detect
// streaming edge detection, first pass of 1x morphological antialiasing
// ----------------------------------------------------------------------------
// channel   modport  handshake      payload
// req_chan  sink     valid / ready  action, red, green, blue, aux_value
// rsp_chan  source   valid / ready  pixel_x, pixel_y, edge_west, edge_north, last
// csr_chan  sink     valid / ready  index, data (ready held high)
//
// one request per clock while the queue has room; results pass stage one, stage two, then the queue
// up to two results per request (two only at a row end), drained through a four-entry output queue
// requests stall only when the queue holds more than two results
// line store read ports are registered; the previous request's write is forwarded
// synchronous reset clears counters, pipeline valids, queue and registers
// ----------------------------------------------------------------------------
`default_nettype none
`include "smaa_edge_detect_macros.svh"

module smaa_edge_detect
   import smaa_ed_pkg::*;
#(
   parameter int MAX_WIDTH = 2048,
   parameter int CHANNEL_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   smaa_req_if.sink  req_chan,
   smaa_rsp_if.source rsp_chan,
   smaa_csr_if.sink  csr_chan
);

   localparam int CB = CHANNEL_BITS;
   localparam int PIX_W = 5 * CB;
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int LS_W = CB + 13;

   // ---------------- configuration registers ----------------
   logic [2:0]  mode_ff;
   logic [11:0] width_ff;
   logic [15:0] thr_ff, adapt_ff, pthr_ff, pscale_ff, dthr_ff;
   logic [12:0] pstr_ff;
   logic [31:0] st_ff;
   logic [12:0] fred_ff;
   smaa_cfg_type eval_cfg_ff;
   logic [2:0]  mode_eff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LUMA;
         width_ff <= 12'd1920;
         thr_ff <= 16'd410;
         adapt_ff <= 16'd8192;
         pthr_ff <= 16'd41;
         pstr_ff <= 13'd1638;
         pscale_ff <= 16'd8192;
         dthr_ff <= 16'd410;
      end else if (csr_chan.valid) begin
         case (reg_index_type'(csr_chan.index))
            REG_DETECT_MODE: mode_ff <= csr_chan.data[2:0];
            REG_FRAME_WIDTH: width_ff <= csr_chan.data[11:0];
            REG_EDGE_THRESHOLD: thr_ff <= csr_chan.data;
            REG_ADAPT_FACTOR: adapt_ff <= csr_chan.data;
            REG_PRED_THRESHOLD: pthr_ff <= csr_chan.data;
            REG_PRED_STRENGTH: pstr_ff <= csr_chan.data[12:0];
            REG_PRED_SCALE: pscale_ff <= csr_chan.data;
            REG_DEPTH_THRESHOLD: dthr_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // unknown mode codes behave as luma
   assign mode_eff = (mode_ff > MODE_COLOR_PRED) ? MODE_LUMA : mode_ff;

   // threshold products, registered in st_ff and then in the evaluator settings
   always_ff @(posedge clock) begin
      st_ff <= 32'(pscale_ff) * 32'(thr_ff);
      fred_ff <= 13'd4096 - ((pstr_ff > 13'd4096) ? 13'd4096 : pstr_ff);
      eval_cfg_ff.depth <= mode_eff == MODE_DEPTH;
      eval_cfg_ff.colour <= (mode_eff == MODE_COLOR) || (mode_eff == MODE_COLOR_PRED);
      eval_cfg_ff.pred <= (mode_eff == MODE_LUMA_PRED) || (mode_eff == MODE_COLOR_PRED);
      eval_cfg_ff.pred_thr <= pthr_ff;
      eval_cfg_ff.depth_thr <= dthr_ff;
      eval_cfg_ff.adapt <= adapt_ff;
      if ((mode_eff == MODE_LUMA_PRED) || (mode_eff == MODE_COLOR_PRED)) begin
         eval_cfg_ff.lim_full <= LIM_W'({st_ff, 12'd0});
         eval_cfg_ff.lim_red <= LIM_W'(fred_ff) * LIM_W'(st_ff);
      end else begin
         eval_cfg_ff.lim_full <= LIM_W'({thr_ff, 24'd0});
         eval_cfg_ff.lim_red <= LIM_W'({thr_ff, 24'd0});
      end
   end

   // ---------------- output queue and advance ----------------
   smaa_res_type fifo_ff [FIFO_DEPTH];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] fifo_cnt_ff;
   logic adv;

   // the whole pipeline moves while the queue has room for two results
   assign adv = fifo_cnt_ff <= 3'd2;
   assign req_chan.ready = adv;

   // ---------------- request stage: counters and store read ----------------
   logic [XW-1:0] col_ff, wm1, c_new;
   logic [11:0]   row_ff;
   logic [1:0]    slot_ff;
   logic [31:0]   fw_ext;
   logic          acc, ignore, row_end;

   assign fw_ext = 32'(width_ff);
   always_comb begin
      if (fw_ext == 32'd0) begin
         wm1 = '0;
      end else if (fw_ext > 32'(MAX_WIDTH)) begin
         wm1 = XW'(MAX_WIDTH - 1);
      end else begin
         wm1 = XW'(fw_ext - 32'd1);
      end
      c_new = (col_ff > wm1) ? wm1 : col_ff;
   end

   assign acc = req_chan.valid && adv;
   // a flush with no row behind it is dropped
   assign ignore = (req_chan.action == ACT_FLUSH) && (row_ff == 12'd0);
   assign row_end = c_new == wm1;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         slot_ff <= 2'd0;
      end else if (acc) begin
         if (ignore) begin
            col_ff <= c_new;
         end else if (row_end) begin
            col_ff <= '0;
            if (req_chan.action == ACT_FLUSH) begin
               row_ff <= '0;
               slot_ff <= 2'd0;
            end else begin
               row_ff <= row_ff + 12'd1;
               // slot tracks row modulo three, restarting when the row wraps
               slot_ff <= ((row_ff == 12'hFFF) || (slot_ff == 2'd2)) ? 2'd0
                          : slot_ff + 2'd1;
            end
         end else begin
            col_ff <= c_new + XW'(1);
         end
      end
   end

   // ---------------- stage one: pixel assembly ----------------
   logic          s1_valid_ff, s1_flush_ff, s1_r0_ff, s1_r1_ff, s1_r2_ff;
   logic          s1_emit_a_ff, s1_emit_b_ff, s1_last_ff;
   logic [4*CB-1:0] s1_pix_ff;
   logic [XW-1:0] s1_col_ff;
   logic [11:0]   s1_row_ff;
   logic [1:0]    s1_slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= acc && !ignore;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_pix_ff <= {req_chan.aux_value, req_chan.blue, req_chan.green, req_chan.red};
         s1_flush_ff <= req_chan.action == ACT_FLUSH;
         s1_col_ff <= c_new;
         s1_row_ff <= row_ff;
         s1_slot_ff <= slot_ff;
         s1_r0_ff <= row_ff == 12'd0;
         s1_r1_ff <= row_ff == 12'd1;
         s1_r2_ff <= row_ff == 12'd2;
         s1_emit_a_ff <= (row_ff != 12'd0) && (c_new != '0);
         s1_emit_b_ff <= (row_ff != 12'd0) && row_end;
         s1_last_ff <= (req_chan.action == ACT_FLUSH) && row_end;
      end
   end

   // line store banks, one per row slot
   logic [PIX_W-1:0] rd_ff [3];
   logic [PIX_W-1:0] bank_d [3];
   logic [PIX_W-1:0] fwd_data_ff, cur;
   logic [2:0]       fwd_hit_ff;
   logic             wr_en;
   logic [LS_W-1:0]  luma_sum;
   logic [1:0]       pm1, pm2;
   logic [PIX_W-1:0] v_col [4];

   assign wr_en = adv && s1_valid_ff;

   for (genvar b = 0; b < 3; b++) begin : g_bank
      logic [PIX_W-1:0] mem [MAX_WIDTH];
      always_ff @(posedge clock) begin
         if (adv) begin
            rd_ff[b] <= mem[c_new];
         end
         if (wr_en && (s1_slot_ff == 2'(b))) begin
            mem[s1_col_ff] <= cur;
         end
      end
      assign bank_d[b] = fwd_hit_ff[b] ? fwd_data_ff : rd_ff[b];
   end

   // width one: the previous request writes the column being read
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= '0;
      end else if (adv) begin
         for (int b = 0; b < 3; b++) begin
            fwd_hit_ff[b] <= wr_en && (s1_slot_ff == 2'(b)) && (s1_col_ff == c_new);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fwd_data_ff <= cur;
      end
   end

   always_comb begin
      luma_sum = LS_W'(LUMA_R) * LS_W'(s1_pix_ff[0 +: CB])
               + LS_W'(LUMA_G) * LS_W'(s1_pix_ff[CB +: CB])
               + LS_W'(LUMA_B) * LS_W'(s1_pix_ff[2*CB +: CB])
               + LS_W'(LUMA_RND);
      pm1 = (s1_slot_ff == 2'd0) ? 2'd2 : s1_slot_ff - 2'd1;
      pm2 = (s1_slot_ff == 2'd0) ? 2'd1 : ((s1_slot_ff == 2'd1) ? 2'd2 : 2'd0);
      // a flush replays the stored pixel of the row above
      cur = s1_flush_ff ? bank_d[pm1] : {luma_sum[12 +: CB], s1_pix_ff};
      // rows y-2 .. y+1, clamped at the top
      v_col[3] = cur;
      v_col[2] = s1_r0_ff ? cur : bank_d[pm1];
      v_col[1] = s1_r0_ff ? cur : (s1_r1_ff ? bank_d[pm1] : bank_d[pm2]);
      if (s1_r0_ff) begin
         v_col[0] = cur;
      end else if (s1_r1_ff) begin
         v_col[0] = bank_d[pm1];
      end else if (s1_r2_ff) begin
         v_col[0] = bank_d[pm2];
      end else begin
         v_col[0] = bank_d[s1_slot_ff];
      end
   end

   // ---------------- stage two: column window and evaluation ----------------
   logic [PIX_W-1:0] win_ff [4][4];
   logic          s2_valid_ff, s2_emit_a_ff, s2_emit_b_ff, s2_last_ff;
   logic [10:0]   s2_xa_ff, s2_xb_ff;
   logic [11:0]   s2_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int k = 0; k < 4; k++) begin
            if (s1_col_ff == '0) begin
               // first column replicates west of the border
               for (int j = 0; j < 4; j++) begin
                  win_ff[j][k] <= v_col[k];
               end
            end else begin
               win_ff[0][k] <= win_ff[1][k];
               win_ff[1][k] <= win_ff[2][k];
               win_ff[2][k] <= win_ff[3][k];
               win_ff[3][k] <= v_col[k];
            end
         end
         s2_xa_ff <= 11'(s1_col_ff - XW'(1));
         s2_xb_ff <= 11'(s1_col_ff);
         s2_y_ff <= s1_row_ff - 12'd1;
         s2_emit_a_ff <= s1_emit_a_ff;
         s2_emit_b_ff <= s1_emit_b_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   logic west_a, north_a, west_b, north_b;

   // pixel one column behind the newest
   smaa_ed_eval #(.CHANNEL_BITS(CHANNEL_BITS)) u_eval_a (
      .cfg        (eval_cfg_ff),
      .pix_ll     (win_ff[0][2]),
      .pix_l      (win_ff[1][2]),
      .pix_h      (win_ff[2][2]),
      .pix_r      (win_ff[3][2]),
      .pix_t2     (win_ff[2][0]),
      .pix_t1     (win_ff[2][1]),
      .pix_bt     (win_ff[2][3]),
      .edge_west  (west_a),
      .edge_north (north_a)
   );

   // last pixel of the row, east border replicated
   smaa_ed_eval #(.CHANNEL_BITS(CHANNEL_BITS)) u_eval_b (
      .cfg        (eval_cfg_ff),
      .pix_ll     (win_ff[1][2]),
      .pix_l      (win_ff[2][2]),
      .pix_h      (win_ff[3][2]),
      .pix_r      (win_ff[3][2]),
      .pix_t2     (win_ff[3][0]),
      .pix_t1     (win_ff[3][1]),
      .pix_bt     (win_ff[3][3]),
      .edge_west  (west_b),
      .edge_north (north_b)
   );

   // ---------------- output queue ----------------
   smaa_res_type res_a, res_b;
   logic push_a, push_b, pop;
   logic [1:0] wr_b;

   assign res_a = '{pixel_x: s2_xa_ff, pixel_y: s2_y_ff, edge_west: west_a,
                    edge_north: north_a, last: 1'b0};
   assign res_b = '{pixel_x: s2_xb_ff, pixel_y: s2_y_ff, edge_west: west_b,
                    edge_north: north_b, last: s2_last_ff};
   assign push_a = adv && s2_valid_ff && s2_emit_a_ff;
   assign push_b = adv && s2_valid_ff && s2_emit_b_ff;
   assign wr_b = s2_emit_a_ff ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
   assign pop = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (push_a) begin
         fifo_ff[wr_ptr_ff] <= res_a;
      end
      if (push_b) begin
         fifo_ff[wr_b] <= res_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + 2'(push_a) + 2'(push_b);
         rd_ptr_ff <= rd_ptr_ff + 2'(pop);
         fifo_cnt_ff <= fifo_cnt_ff + 3'(push_a) + 3'(push_b) - 3'(pop);
      end
   end

   assign rsp_chan.valid = fifo_cnt_ff != 3'd0;
   assign rsp_chan.pixel_x = fifo_ff[rd_ptr_ff].pixel_x;
   assign rsp_chan.pixel_y = fifo_ff[rd_ptr_ff].pixel_y;
   assign rsp_chan.edge_west = fifo_ff[rd_ptr_ff].edge_west;
   assign rsp_chan.edge_north = fifo_ff[rd_ptr_ff].edge_north;
   assign rsp_chan.last = fifo_ff[rd_ptr_ff].last;

   // ---------------- assertions ----------------
   `SMAA_ASSERT_NOW(a_fifo_bound, 1'b1, fifo_cnt_ff <= 3'(FIFO_DEPTH), "output queue overflow")
   `SMAA_ASSERT_NOW(a_push_room, s2_valid_ff && adv, fifo_cnt_ff <= 3'd2, "push without room")
   `SMAA_ASSERT_NOW(a_slot_top, row_ff == 12'd0, slot_ff == 2'd0, "row slot out of step")
   `SMAA_ASSERT_NOW(a_fwd_one, 1'b1, $onehot0(fwd_hit_ff), "forward hits several banks")

endmodule

`default_nettype wire

FILE: tb/sv/smaa_edge_detect_tb.sv
// ----------------------------------------------------------------------------
// smaa_edge_detect_tb
// self-checking bench for the streaming edge detection block: a directed
// table, width changes, then random frames with random settings, every result
// checked against an in-bench model of the edge evaluator, line stores and window
// ----------------------------------------------------------------------------
`default_nettype none

module smaa_edge_detect_tb;
   import smaa_ed_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAXW = 2048;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 750;

   typedef struct packed {
      logic [15:0] r;
      logic [15:0] g;
      logic [15:0] b;
      logic [15:0] a;
   } pix_type;

   typedef struct {
      logic act;
      pix_type px;
      int nres;   // -1: predictor only
   } dir_row_type;

   logic clock;
   logic reset;

   smaa_req_if #(.CHANNEL_BITS(16)) req_bus ();
   smaa_rsp_if rsp_bus ();
   smaa_csr_if csr_bus ();

   smaa_edge_detect #(.MAX_WIDTH(MAXW), .CHANNEL_BITS(16)) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_chan(csr_bus)
   );

   // model copy of the settings
   logic [2:0] m_mode;
   logic [11:0] m_width;
   logic [15:0] m_edge_thr, m_adapt, m_pred_thr, m_pred_scale, m_depth_thr;
   logic [12:0] m_pred_str;

   // model copy of the storage
   pix_type line_mem [3*MAXW];
   pix_type win [16];
   int col_cnt, row_cnt;

   smaa_res_type edge_q [$];

   int errors = 0;
   int n_requests = 0;
   int n_results = 0;
   int n_frames = 0;
   int n_csr = 0;
   int idle_cycles = 0;
   bit send_idle = 1;
   bit recv_idle = 1;

   // clock
   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   task automatic report(input string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // ------------------------------------------------------------------------
   // edge model
   // ------------------------------------------------------------------------
   function automatic logic [31:0] absd(input logic [31:0] x, input logic [31:0] y);
      return (x > y) ? x - y : y - x;
   endfunction

   function automatic logic [31:0] luma_of(input pix_type p);
      logic [63:0] s;
      s = 64'(p.r) * 871 + 64'(p.g) * 2929 + 64'(p.b) * 296 + 64'd2048;
      return 32'(s >> 12);
   endfunction

   function automatic logic [31:0] pix_delta(input pix_type x, input pix_type y,
                                             input bit colour);
      logic [31:0] d;
      if (!colour) return absd(luma_of(x), luma_of(y));
      d = absd(x.r, y.r);
      if (absd(x.g, y.g) > d) d = absd(x.g, y.g);
      if (absd(x.b, y.b) > d) d = absd(x.b, y.b);
      return d;
   endfunction

   function automatic logic [63:0] edge_limit(input pix_type h, input pix_type n,
                                              input bit pred);
      logic [63:0] f;
      f = 64'd4096;
      if (!pred) return 64'(m_edge_thr) << 24;
      if (absd(h.a, n.a) >= 32'(m_pred_thr))
         f = f - ((m_pred_str > 13'd4096) ? 64'd4096 : 64'(m_pred_str));
      return f * 64'(m_pred_scale) * 64'(m_edge_thr);
   endfunction

   function automatic smaa_res_type edge_eval(input int ca, input int cb, input int cc,
                                              input int cd, input int x, input int y,
                                              input bit last);
      smaa_res_type res;
      pix_type ll, l, h, rt, t2, t1, bt;
      logic [2:0] mode;
      bit colour, pred;
      logic [31:0] dl, dt, fin;
      ll = win[ca*4+2];
      l = win[cb*4+2];
      h = win[cc*4+2];
      rt = win[cd*4+2];
      t2 = win[cc*4+0];
      t1 = win[cc*4+1];
      bt = win[cc*4+3];
      mode = (m_mode > MODE_COLOR_PRED) ? MODE_LUMA : m_mode;
      res.pixel_x = 11'(x);
      res.pixel_y = 12'(y);
      res.last = last;
      if (mode == MODE_DEPTH) begin
         res.edge_west = absd(h.a, l.a) >= 32'(m_depth_thr);
         res.edge_north = absd(h.a, t1.a) >= 32'(m_depth_thr);
         return res;
      end
      colour = (mode == MODE_COLOR || mode == MODE_COLOR_PRED);
      pred = (mode == MODE_LUMA_PRED || mode == MODE_COLOR_PRED);
      dl = pix_delta(h, l, colour);
      dt = pix_delta(h, t1, colour);
      res.edge_west = (64'(dl) << 24) >= edge_limit(h, l, pred);
      res.edge_north = (64'(dt) << 24) >= edge_limit(h, t1, pred);
      fin = (dl > dt) ? dl : dt;
      if (pix_delta(h, rt, colour) > fin) fin = pix_delta(h, rt, colour);
      if (pix_delta(h, bt, colour) > fin) fin = pix_delta(h, bt, colour);
      if (pix_delta(l, ll, colour) > fin) fin = pix_delta(l, ll, colour);
      if (pix_delta(t1, t2, colour) > fin) fin = pix_delta(t1, t2, colour);
      // local contrast adaptation drops weak edges next to strong ones
      if ((64'(fin) << 12) > 64'(m_adapt) * 64'(dl)) res.edge_west = 0;
      if ((64'(fin) << 12) > 64'(m_adapt) * 64'(dt)) res.edge_north = 0;
      return res;
   endfunction

   function automatic int eff_width();
      int w;
      w = m_width;
      if (w < 1) w = 1;
      if (w > MAXW) w = MAXW;
      return w;
   endfunction

   // advance the model by one request, queue the edge results it causes
   task automatic predict_edges(input logic flush, input pix_type px, output int n);
      int w, c, r, k, i, j;
      pix_type cur;
      pix_type v [4];
      bit row_end;
      n = 0;
      w = eff_width();
      if (col_cnt > w - 1) col_cnt = w - 1;
      // flush at row zero is dropped
      if (flush && row_cnt == 0) return;
      c = col_cnt;
      r = row_cnt;
      cur = flush ? line_mem[((r - 1) % 3) * MAXW + c] : px;
      v[3] = cur;
      for (j = 1; j <= 3; j++) begin
         k = (r >= j) ? r - j : 0;
         v[3-j] = (k == r) ? cur : line_mem[(k % 3) * MAXW + c];
      end
      line_mem[(r % 3) * MAXW + c] = cur;
      if (c == 0) begin
         for (i = 0; i < 4; i++)
            for (j = 0; j < 4; j++) win[i*4+j] = v[j];
      end else begin
         for (i = 0; i < 12; i++) win[i] = win[i+4];
         for (j = 0; j < 4; j++) win[12+j] = v[j];
      end
      row_end = (c == w - 1);
      if (r >= 1) begin
         if (c >= 1) begin
            edge_q.push_back(edge_eval(0, 1, 2, 3, c - 1, r - 1, 1'b0));
            n++;
         end
         if (row_end) begin
            edge_q.push_back(edge_eval(1, 2, 3, 3, c, r - 1, flush));
            n++;
         end
      end
      if (row_end) begin
         col_cnt = 0;
         if (flush) begin
            row_cnt = 0;
            n_frames++;
         end else begin
            row_cnt = (r + 1) % 4096;
         end
      end else begin
         col_cnt = c + 1;
      end
   endtask

   task automatic model_reset();
      m_mode = MODE_LUMA;
      m_width = 12'd1920;
      m_edge_thr = 16'd410;
      m_adapt = 16'd8192;
      m_pred_thr = 16'd41;
      m_pred_str = 13'd1638;
      m_pred_scale = 16'd8192;
      m_depth_thr = 16'd410;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
   endtask

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   task automatic csr_write(input logic [3:0] idx, input logic [15:0] value);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data = value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         REG_DETECT_MODE: m_mode = value[2:0];
         REG_FRAME_WIDTH: m_width = value[11:0];
         REG_EDGE_THRESHOLD: m_edge_thr = value;
         REG_ADAPT_FACTOR: m_adapt = value;
         REG_PRED_THRESHOLD: m_pred_thr = value;
         REG_PRED_STRENGTH: m_pred_str = value[12:0];
         REG_PRED_SCALE: m_pred_scale = value;
         REG_DEPTH_THRESHOLD: m_depth_thr = value;
         default: ;
      endcase
      n_csr++;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // one request, with a random lead-in gap; returns the model's result count
   task automatic send_request(input logic act, input pix_type px, output int n);
      int gap;
      gap = send_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.action = act;
      req_bus.red = px.r;
      req_bus.green = px.g;
      req_bus.blue = px.b;
      req_bus.aux_value = px.a;
      do @(posedge clock); while (!req_bus.ready);
      n_requests++;
      predict_edges(act, px, n);
      @(negedge clock);
   endtask

   // settings change only once every result is out and the pipe has drained
   task automatic wait_idle();
      req_bus.valid = 1'b0;
      while (edge_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   // result side: random ready gaps, then hold ready until a result moves
   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = recv_idle ? $urandom_range(0, 7) : 0;
         if (gap > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   // result checker
   always @(posedge clock) begin
      smaa_res_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         n_results++;
         if (edge_q.size() == 0) begin
            report($sformatf("unexpected result x=%0d y=%0d", rsp_bus.pixel_x,
                             rsp_bus.pixel_y));
         end else begin
            want = edge_q.pop_front();
            if (rsp_bus.pixel_x !== want.pixel_x || rsp_bus.pixel_y !== want.pixel_y ||
                rsp_bus.edge_west !== want.edge_west ||
                rsp_bus.edge_north !== want.edge_north || rsp_bus.last !== want.last)
               report($sformatf("got x=%0d y=%0d w=%b n=%b l=%b, want x=%0d y=%0d w=%b n=%b l=%b",
                                rsp_bus.pixel_x, rsp_bus.pixel_y, rsp_bus.edge_west,
                                rsp_bus.edge_north, rsp_bus.last, want.pixel_x,
                                want.pixel_y, want.edge_west, want.edge_north, want.last));
         end
      end
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("smaa_edge_detect_tb: done, errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [15:0] near(input logic [15:0] base);
      int v;
      v = int'(base) + $urandom_range(0, 1200) - 600;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return 16'(v);
   endfunction

   // mostly small steps around a base color so edges sit near the thresholds
   function automatic pix_type rand_pixel(input pix_type base);
      pix_type p;
      case ($urandom_range(0, 7))
         0, 1: p = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
         2: p = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, $urandom_range(0, 1) ? 16'hFFFF : 16'h0,
                 $urandom_range(0, 1) ? 16'hFFFF : 16'h0, $urandom_range(0, 1) ? 16'hFFFF : 16'h0};
         default: p = {near(base.r), near(base.g), near(base.b), near(base.a)};
      endcase
      return p;
   endfunction

   function automatic logic [15:0] rand_level(input int span);
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, span));
      endcase
   endfunction

   // a frame: some pixel rows, then one flush row
   task automatic run_frame(input int rows, inout int budget);
      int w, y, x, n;
      pix_type base, px;
      w = eff_width();
      base = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      for (y = 0; y < rows; y++)
         for (x = 0; x < w; x++) begin
            px = rand_pixel(base);
            if ($urandom_range(0, 3) == 0) base = px;
            send_request(ACT_PIXEL, px, n);
            budget--;
         end
      for (x = 0; x < w; x++) begin
         px = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
         send_request(ACT_FLUSH, px, n);
         budget--;
      end
   endtask

   // ------------------------------------------------------------------------
   // directed table: width 3, luma mode, default thresholds
   // ------------------------------------------------------------------------
   dir_row_type dir_table [11];

   initial begin
      int n, i, budget;
      pix_type px;

      dir_table = '{
         '{ACT_FLUSH, 64'h0, 0},                            // flush at row zero, dropped
         '{ACT_PIXEL, {16'h0000, 16'h0000, 16'h0000, 16'h0000}, 0},
         '{ACT_PIXEL, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 0},
         '{ACT_PIXEL, {16'h0000, 16'hFFFF, 16'h0000, 16'h8000}, 0},
         '{ACT_PIXEL, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, 0},
         '{ACT_PIXEL, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1},
         '{ACT_PIXEL, {16'h0000, 16'h0000, 16'h0000, 16'h0000}, 2}, // row end, two results
         '{ACT_FLUSH, 64'h0, 0},
         '{ACT_FLUSH, 64'h0, 1},
         '{ACT_FLUSH, 64'h0, 2},                            // frame end, last set
         '{ACT_FLUSH, 64'h0, 0}                             // dropped again
      };

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.action = ACT_PIXEL;
      req_bus.red = '0;
      req_bus.green = '0;
      req_bus.blue = '0;
      req_bus.aux_value = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      model_reset();
      repeat (10) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed part
      csr_write(REG_FRAME_WIDTH, 16'd3);
      foreach (dir_table[i]) begin
         send_request(dir_table[i].act, dir_table[i].px, n);
         if (dir_table[i].nres >= 0 && n != dir_table[i].nres)
            report($sformatf("table row %0d: model gives %0d results, table %0d",
                             i, n, dir_table[i].nres));
      end
      wait_idle();

      // width shrink mid row: the column count is pulled back and ends the row
      csr_write(REG_FRAME_WIDTH, 16'd5);
      for (i = 0; i < 13; i++) begin
         px = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
         send_request(ACT_PIXEL, px, n);
      end
      wait_idle();
      csr_write(REG_FRAME_WIDTH, 16'd2);
      send_request(ACT_PIXEL, 64'h1234_5678_9ABC_DEF0, n);
      send_request(ACT_FLUSH, 64'h0, n);
      send_request(ACT_FLUSH, 64'h0, n);
      wait_idle();

      // random phases: fresh settings at every frame boundary
      budget = RANDOM_ITEMS;
      while (budget > 0) begin
         send_idle = ($urandom_range(0, 3) != 0);
         recv_idle = ($urandom_range(0, 3) != 0);
         csr_write(REG_DETECT_MODE,
                   16'($urandom_range(0, 7)) | 16'($urandom_range(0, 1) << 8));
         case ($urandom_range(0, 9))
            0: csr_write(REG_FRAME_WIDTH, 16'h0000);
            1: csr_write(REG_FRAME_WIDTH, 16'($urandom_range(9, 24)));
            2: csr_write(REG_FRAME_WIDTH, 16'h1000 | 16'($urandom_range(1, 6)));
            default: csr_write(REG_FRAME_WIDTH, 16'($urandom_range(1, 8)));
         endcase
         csr_write(REG_EDGE_THRESHOLD, rand_level(3000));
         csr_write(REG_ADAPT_FACTOR, rand_level(20000));
         csr_write(REG_PRED_THRESHOLD, rand_level(3000));
         case ($urandom_range(0, 3))
            0: csr_write(REG_PRED_STRENGTH, 16'd4096);
            1: csr_write(REG_PRED_STRENGTH, 16'($urandom));
            default: csr_write(REG_PRED_STRENGTH, 16'($urandom_range(0, 4096)));
         endcase
         csr_write(REG_PRED_SCALE, rand_level(16384));
         csr_write(REG_DEPTH_THRESHOLD, rand_level(3000));
         // unused register slot, must change nothing
         if ($urandom_range(0, 5) == 0)
            csr_write(4'($urandom_range(8, 15)), 16'($urandom));
         // noise: a flush while no frame is open
         if ($urandom_range(0, 4) == 0) begin
            send_request(ACT_FLUSH, {16'($urandom), 16'($urandom), 16'($urandom),
                                     16'($urandom)}, n);
         end
         run_frame($urandom_range(1, 5), budget);
         wait_idle();
      end

      // drain
      req_bus.valid = 1'b0;
      while (edge_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("covered %0d requests, %0d results, %0d frames, %0d register writes",
               n_requests, n_results, n_frames, n_csr);
      $display("modes, clamped widths, width shrink mid row and flush replay exercised");
      if (errors == 0) begin
         $display("smaa_edge_detect_tb: done, clean");
      end else begin
         $display("%0d mismatches", errors);
         $display("smaa_edge_detect_tb: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/smaa_ed_pkg.sv
rtl/smaa_ed_if.sv
rtl/smaa_ed_eval.sv
rtl/smaa_edge_detect.sv
tb/sv/smaa_edge_detect_tb.sv
